// ===== src/ndac_pkg.sv =====
`default_nettype none
package ndac_pkg;

  localparam logic [1:0] FUNC_UNSIGNED = 2'd0;
  localparam logic [1:0] FUNC_SIGNED   = 2'd1;
  localparam logic [1:0] FUNC_FIXED    = 2'd2;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_POINT = 7'h2E;

  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  // f / 10 == (f * TENS_MUL) >> TENS_SHIFT for f below 100
  localparam logic [7:0]  TENS_MUL    = 8'd205;
  localparam int          TENS_SHIFT  = 11;
  localparam logic [6:0]  FRAC_SCALE  = 7'd100;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_DIGITS  = 5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  // classified number handed from front to back
  typedef struct packed {
    logic        neg;
    logic        fixq;
    logic [15:0] mag;
    logic [6:0]  fdisp;
  } desc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIG,
    S_POINT,
    S_TENS,
    S_ONES
  } back_state_e;

endpackage
`default_nettype wire

// ===== src/ndac_front.sv =====
`default_nettype none
module ndac_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ndac_pkg::in_item_t in_item_i,
  output logic                   push_valid_o,
  input  wire logic              push_full_i,
  output ndac_pkg::desc_t        push_desc_o
);

  logic            valid_q, valid_d;
  ndac_pkg::desc_t desc_q, desc_d;
  logic            accept;
  logic            is_signed;
  logic [15:0]     absval;
  logic [14:0]     frac_prod;

  assign in_stall_o   = valid_q & push_full_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

  always_comb begin
    unique case (in_item_i.func)
      ndac_pkg::FUNC_SIGNED, ndac_pkg::FUNC_FIXED: is_signed = 1'b1;
      ndac_pkg::FUNC_UNSIGNED, ndac_pkg::FUNC_RESERVED: is_signed = 1'b0;
      default: is_signed = 1'b0;
    endcase
  end

  always_comb begin
    desc_d.neg  = is_signed & in_item_i.value[15];
    absval      = desc_d.neg ? (~in_item_i.value + 16'd1) : in_item_i.value;
    desc_d.fixq = (in_item_i.func == ndac_pkg::FUNC_FIXED);
    frac_prod   = 15'(absval[7:0]) * 15'(ndac_pkg::FRAC_SCALE);
    if (desc_d.fixq) begin
      desc_d.mag = {8'd0, absval[15:8]};
    end else begin
      desc_d.mag = absval;
    end
    desc_d.fdisp = frac_prod[14:8];
  end

  assign valid_d = (valid_q & push_full_i) | accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/ndac_queue.sv =====
`default_nettype none
module ndac_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ndac_pkg::desc_t push_desc_i,
  output logic                 full_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_i,
  output ndac_pkg::desc_t      pop_desc_o
);

  localparam int PtrW = $clog2(ndac_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(ndac_pkg::QUEUE_DEPTH + 1);

  ndac_pkg::desc_t mem_q [ndac_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(ndac_pkg::QUEUE_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_desc_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ndac_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ndac_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/ndac_back.sv =====
`default_nettype none
module ndac_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  input  wire ndac_pkg::desc_t  pop_desc_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ndac_pkg::out_item_t   out_item_o
);

  localparam int CntW = $clog2(ndac_pkg::MAX_DIGITS + 1);
  localparam int IdxW = $clog2(ndac_pkg::MAX_DIGITS);

  ndac_pkg::back_state_e state_q, state_d;
  logic [15:0]         mag_q;
  logic                neg_q, fixq_q;
  logic [6:0]          fdisp_q;
  logic [3:0]          dig_q [ndac_pkg::MAX_DIGITS];
  logic [CntW-1:0]     cnt_q;
  logic                out_valid_q;
  ndac_pkg::out_item_t out_item_q;

  logic                out_free;
  logic                emit;
  ndac_pkg::out_item_t emit_item;
  logic [31:0]         div_prod;
  logic [15:0]         quo;
  logic [15:0]         quo_x10;
  logic [15:0]         rem_full;
  logic [14:0]         tens_prod;
  logic [3:0]          tens;
  logic [6:0]          ones_full;
  logic [IdxW-1:0]     top_idx;
  logic                last_digit;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // one decimal digit per cycle: divide by ten through a reciprocal multiply
  assign div_prod = mag_q * ndac_pkg::DIV10_MUL;
  assign quo      = 16'(div_prod >> ndac_pkg::DIV10_SHIFT);
  assign quo_x10  = 16'({quo, 3'b000}) + 16'({quo, 1'b0});
  assign rem_full = mag_q - quo_x10;

  assign tens_prod = fdisp_q * ndac_pkg::TENS_MUL;
  assign tens      = 4'(tens_prod >> ndac_pkg::TENS_SHIFT);
  assign ones_full = fdisp_q - 7'({tens, 3'b000}) - 7'({tens, 1'b0});

  assign top_idx    = IdxW'(cnt_q - CntW'(1));
  assign last_digit = (cnt_q == CntW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ndac_pkg::S_IDLE: begin
        if (pop_valid_i) state_d = ndac_pkg::S_DIV;
      end
      ndac_pkg::S_DIV: begin
        if (quo == 16'd0) state_d = neg_q ? ndac_pkg::S_SIGN : ndac_pkg::S_DIG;
      end
      ndac_pkg::S_SIGN: begin
        if (out_free) state_d = ndac_pkg::S_DIG;
      end
      ndac_pkg::S_DIG: begin
        if (out_free && last_digit) begin
          state_d = fixq_q ? ndac_pkg::S_POINT : ndac_pkg::S_IDLE;
        end
      end
      ndac_pkg::S_POINT: begin
        if (out_free) state_d = ndac_pkg::S_TENS;
      end
      ndac_pkg::S_TENS: begin
        if (out_free) state_d = ndac_pkg::S_ONES;
      end
      ndac_pkg::S_ONES: begin
        if (out_free) state_d = ndac_pkg::S_IDLE;
      end
      default: state_d = ndac_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    unique case (state_q)
      ndac_pkg::S_IDLE: pop_o = pop_valid_i;
      ndac_pkg::S_DIV: ;
      ndac_pkg::S_SIGN: begin
        emit                = out_free;
        emit_item.char_code = ndac_pkg::CHAR_MINUS;
      end
      ndac_pkg::S_DIG: begin
        emit                = out_free;
        emit_item.char_code = ndac_pkg::CHAR_ZERO + {3'b000, dig_q[top_idx]};
        emit_item.last      = last_digit & ~fixq_q;
      end
      ndac_pkg::S_POINT: begin
        emit                = out_free;
        emit_item.char_code = ndac_pkg::CHAR_POINT;
      end
      ndac_pkg::S_TENS: begin
        emit                = out_free;
        emit_item.char_code = ndac_pkg::CHAR_ZERO + {3'b000, tens};
      end
      ndac_pkg::S_ONES: begin
        emit                = out_free;
        emit_item.char_code = ndac_pkg::CHAR_ZERO + {3'b000, ones_full[3:0]};
        emit_item.last      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ndac_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ndac_pkg::S_DIV) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (state_q == ndac_pkg::S_DIG && out_free) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mag_q   <= pop_desc_i.mag;
      neg_q   <= pop_desc_i.neg;
      fixq_q  <= pop_desc_i.fixq;
      fdisp_q <= pop_desc_i.fdisp;
    end else if (state_q == ndac_pkg::S_DIV) begin
      mag_q                    <= quo;
      dig_q[IdxW'(cnt_q)]      <= rem_full[3:0];
    end
    if (emit) begin
      out_item_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ===== src/number_to_decimal_ascii_core.sv =====
// Binary to decimal ASCII converter.
// Input channel (in_valid_i / in_stall_o / in_item_i): one 16-bit value and a
// format code: unsigned, signed two's complement, or signed Q8.8 (code 3
// prints as unsigned). Output channel (out_valid_o / out_stall_i /
// out_item_o): the text one character per item, most significant first,
// with last set on the final character. Leading zeros are dropped, zero
// prints as "0", Q8.8 prints integer part, '.', and two fraction digits.
// A front register classifies the number, a two-entry queue decouples it
// from the back end, which divides by ten once per cycle and then emits.
// The first character leaves the output register after the number has passed
// the front register, the queue and the back end's divide loop, which runs
// once per integer digit D (1 to 5); a leading '-' comes out first.
// The back end handles one number at a time and pops the next only when
// idle; it emits a number's characters (at most 7) one per cycle unless the
// output stalls, while front and queue can take further numbers meanwhile.
// Reset empties the front, the queue and the output register at once.
// A stalled output holds its character; the back end then waits, the queue
// fills, and in_stall_o rises once front and queue are both occupied.
`default_nettype none
module number_to_decimal_ascii_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ndac_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ndac_pkg::out_item_t      out_item_o
);

  logic            push_valid, queue_full, pop_valid, pop;
  ndac_pkg::desc_t push_desc, pop_desc;

  ndac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_full_i  (queue_full),
    .push_desc_o  (push_desc)
  );

  ndac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_desc_i (push_desc),
    .full_o      (queue_full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc)
  );

  ndac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_desc_i  (pop_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== src/ndac_checker.sv =====
`default_nettype none
module ndac_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire ndac_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ndac_pkg::out_item_t out_item_o
);

  logic is_digit;
  assign is_digit = (out_item_o.char_code >= ndac_pkg::CHAR_ZERO) &&
                    (out_item_o.char_code <= ndac_pkg::CHAR_ZERO + 7'd9);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled output item changed");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_digit || out_item_o.char_code == ndac_pkg::CHAR_MINUS ||
                    out_item_o.char_code == ndac_pkg::CHAR_POINT)
    else $error("unexpected character code");

  a_no_last_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.char_code == ndac_pkg::CHAR_MINUS ||
                    out_item_o.char_code == ndac_pkg::CHAR_POINT) |-> !out_item_o.last)
    else $error("number ends on sign or point");

  a_digit_after_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_item_o.char_code == ndac_pkg::CHAR_MINUS ||
                    out_item_o.char_code == ndac_pkg::CHAR_POINT) |=> out_valid_o && is_digit)
    else $error("sign or point not followed at once by a digit");

endmodule

bind number_to_decimal_ascii_core ndac_checker u_ndac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
